// ===== design/llja_pkg.sv =====
// llja_pkg: shared constants and types for the least-loaded job assigner
// no dependencies
package llja_pkg;
	localparam int LINES = 64;
	localparam int IDX_W = $clog2(LINES);
	localparam int CNT_W = $clog2(LINES + 1);
	localparam int LOAD_W = 32;
	localparam int JOB_W = 16;
	localparam int NL_W = 7;
	localparam int CFG_W = 32;
	localparam logic CFG_NUM_LINES = 1'b0;
	localparam logic CFG_LOAD_LIMIT = 1'b1;
	localparam logic KIND_CLEAR = 1'b0;
	localparam logic KIND_JOB = 1'b1;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [LOAD_W-1:0] wdata;
	} mem_req_t;
endpackage

// ===== design/llja_load_ram.sv =====
// llja_load_ram: one-read one-write load memory, registered read
// depends on llja_pkg
module llja_load_ram import llja_pkg::*; (
	input  logic              clk,
	input  mem_req_t          req,
	output logic [LOAD_W-1:0] rdata
);
	logic [LOAD_W-1:0] mem [LINES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end
endmodule

// ===== design/least_loaded_job_assigner_core.sv =====
// least_loaded_job_assigner_core: top level, scan sequencer and config
// depends on llja_pkg and llja_load_ram
//
// Each job streams the active line loads out of a one-port-read memory, one per
// cycle, keeping the smallest (lowest index on ties), then writes the chosen line
// back with the saturated sum. A clear sweeps the memory, one line a cycle; after
// reset the same sweep runs once with busy high. Results show for one cycle on done
// and cannot be held off.
module least_loaded_job_assigner_core import llja_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [JOB_W-1:0]  job_time,
	input  logic              last_job,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              done,
	output logic [IDX_W-1:0]  chosen_line,
	output logic [LOAD_W-1:0] new_load,
	output logic [LOAD_W-1:0] max_load,
	output logic              within_limit,
	output logic              run_done
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CLR  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_WB   = 2'd3;

	logic [1:0]        state_q;
	logic [NL_W-1:0]   num_lines_q;
	logic [LOAD_W-1:0] limit_q;
	logic [LOAD_W-1:0] peak_q;
	logic [IDX_W-1:0]  raddr_q;   // next line to read
	logic [CNT_W-1:0]  left_q;    // reads still to issue
	logic              vld_s1;    // read data valid this cycle
	logic [IDX_W-1:0]  idx_s1;    // line of the read data
	logic [IDX_W-1:0]  best_q;
	logic [LOAD_W-1:0] best_load_q;
	logic [JOB_W-1:0]  job_q;
	logic              last_q;
	logic              final_s1;  // read data is the last of the scan
	logic [CNT_W-1:0]  n_act;
	logic [LOAD_W-1:0] rdata;
	logic [LOAD_W:0]   sum;
	logic [LOAD_W-1:0] sat;
	logic [LOAD_W-1:0] peak_nx;
	mem_req_t          req;

	// clamp num_lines into 1..LINES
	always_comb begin
		if (num_lines_q == '0) begin
			n_act = CNT_W'(1);
		end else if ({{(32-NL_W){1'b0}}, num_lines_q} > 32'(LINES)) begin
			n_act = CNT_W'(LINES);
		end else begin
			n_act = CNT_W'(num_lines_q);
		end
	end

	// saturating add for the writeback
	assign sum = {1'b0, best_load_q} + {{(LOAD_W+1-JOB_W){1'b0}}, job_q};
	assign sat = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
	assign peak_nx = (sat > peak_q) ? sat : peak_q;

	always_comb begin
		req = '0;
		req.re = (state_q == ST_SCAN) && (left_q != '0);
		req.raddr = raddr_q;
		if (state_q == ST_CLR) begin
			req.we = 1'b1;
			req.waddr = raddr_q;
			req.wdata = '0;
		end else if (state_q == ST_WB) begin
			req.we = 1'b1;
			req.waddr = best_q;
			req.wdata = sat;
		end
	end

	llja_load_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			num_lines_q <= NL_W'(1);
			limit_q <= '1;
			peak_q <= '0;
			raddr_q <= '0;
			left_q <= '0;
			vld_s1 <= 1'b0;
			final_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= req.re;
			final_s1 <= req.re && (left_q == CNT_W'(1));
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_LINES:  num_lines_q <= cfg_data[NL_W-1:0];
					CFG_LOAD_LIMIT: limit_q <= cfg_data[LOAD_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						raddr_q <= '0;
						if (kind == KIND_CLEAR) begin
							state_q <= ST_CLR;
							peak_q <= '0;
							done <= 1'b1;
						end else begin
							state_q <= ST_SCAN;
							left_q <= n_act;
						end
					end
				end
				ST_CLR: begin
					raddr_q <= raddr_q + 1'b1;
					if (raddr_q == IDX_W'(LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (req.re) begin
						raddr_q <= raddr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
					if (final_s1) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					state_q <= ST_IDLE;
					peak_q <= peak_nx;
					done <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: running minimum and the result fields
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			job_q <= job_time;
			last_q <= last_job;
			if (kind == KIND_CLEAR) begin
				chosen_line <= '0;
				new_load <= '0;
				max_load <= '0;
				within_limit <= 1'b1;
				run_done <= last_job;
			end
		end
		idx_s1 <= raddr_q;
		if (vld_s1 && (idx_s1 == '0 || rdata < best_load_q)) begin
			best_q <= idx_s1;
			best_load_q <= rdata;
		end
		if (state_q == ST_WB) begin
			chosen_line <= best_q;
			new_load <= sat;
			max_load <= peak_nx;
			within_limit <= (peak_nx <= limit_q);
			run_done <= last_q;
		end
	end

	// a result strobe only comes out of writeback or a clear start
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_WB) || ($past(state_q) == ST_IDLE && $past(start)))
		else $error("done without a transfer source");
	// peak never falls except on a clear
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |=> (peak_q >= $past(peak_q)))
		else $error("peak decreased on a job");
	// the reported load never exceeds the reported peak
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (new_load <= max_load))
		else $error("new_load above max_load");
endmodule
